// ===== rtl/ftv_pkg.sv =====
// ----------------------------------------------------------------------------
// ftv_pkg
// Shared widths, byte codes and the result word type of the FIX tokeniser.
// ----------------------------------------------------------------------------
`default_nettype none

package ftv_pkg;

  localparam int unsigned MAX_MSG_BYTES_DEF = 4096;

  localparam int BYTE_W = 8;
  localparam int TAG_W  = 31;
  localparam int OFS_W  = 12;
  localparam int OFS_MAX = 4095;

  // Byte codes
  localparam logic [BYTE_W-1:0] EQ_BYTE   = 8'h3D;
  localparam logic [BYTE_W-1:0] SEP_RESET = 8'h01;
  localparam logic [BYTE_W-1:0] DIGIT_0   = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_9   = 8'h39;

  typedef struct packed {
    logic              field_valid;
    logic [TAG_W-1:0]  tag_number;
    logic [OFS_W-1:0]  value_offset;
    logic [OFS_W-1:0]  value_length;
    logic [BYTE_W-1:0] sum_before_field;
    logic              message_end;
    logic              length_overflow;
  } ftv_result_t;

endpackage

`default_nettype wire

// ===== rtl/ftv_if.sv =====
// ----------------------------------------------------------------------------
// ftv_if
// Valid/ready channels of the FIX tokeniser: byte input and field result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftv_in_if;
  import ftv_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ftv_out_if;
  import ftv_pkg::*;

  logic              valid;
  logic              ready;
  logic              field_valid;
  logic [TAG_W-1:0]  tag_number;
  logic [OFS_W-1:0]  value_offset;
  logic [OFS_W-1:0]  value_length;
  logic [BYTE_W-1:0] sum_before_field;
  logic              message_end;
  logic              length_overflow;

  modport source (
    output valid, output field_valid, output tag_number, output value_offset,
    output value_length, output sum_before_field, output message_end,
    output length_overflow, input ready
  );
  modport sink (
    input valid, input field_valid, input tag_number, input value_offset,
    input value_length, input sum_before_field, input message_end,
    input length_overflow, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/fix_tag_value_tokenizer.sv =====
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer
// Streaming splitter of FIX messages into tag=value fields.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle on in_chan, with last marking the
// final byte, and sustains one byte every clock: each byte updates the scan
// state in a single pass of short logic (a constant multiply by ten on the tag,
// a compare against the separator, an 8-bit running sum) and, when it closes a
// field with a non-zero tag that fits in 31 bits or is the last byte, writes
// one word into the result register, or into the one-word skid stage behind
// it while a result waits on out_chan, so the block keeps taking bytes; input
// stalls only when both are full. Byte positions saturate at MAX_MSG_BYTES,
// offsets and lengths at min(MAX_MSG_BYTES-1, 4095), and length_overflow then
// stays high until the message ends. The separator (SOH after reset) is
// written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module fix_tag_value_tokenizer #(
  parameter int unsigned MAX_MSG_BYTES = ftv_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ftv_pkg::BYTE_W-1:0] cfg_wdata,
  ftv_in_if.sink                    in_chan,
  ftv_out_if.source                 out_chan
);
  import ftv_pkg::*;

  // Position width holds MAX_MSG_BYTES itself; XW covers position + 1 and
  // the 12-bit offsets for compares and subtraction.
  localparam int PW = $clog2(MAX_MSG_BYTES + 1);
  localparam int XW = (PW + 1 > OFS_W + 1) ? PW + 1 : OFS_W + 1;
  localparam int unsigned CAP_I =
    (MAX_MSG_BYTES - 1 < OFS_MAX) ? MAX_MSG_BYTES - 1 : OFS_MAX;
  localparam logic [PW-1:0] LIM_P = PW'(MAX_MSG_BYTES);
  localparam logic [XW-1:0] CAP_X = XW'(CAP_I);

  // Scan state
  logic [BYTE_W-1:0] sep_r;
  logic              in_value_r, in_value_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic              run_open_r, run_open_nxt;
  logic              too_big_r, too_big_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [OFS_W-1:0]  vstart_r, vstart_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] fsum_r, fsum_nxt;
  logic              ovf_r, ovf_nxt;

  // Result register and skid stage
  ftv_result_t       out_r, skid_r, res;
  logic              out_v_r, skid_v_r;

  logic              in_fire, has_res, push, out_free;
  logic [BYTE_W-1:0] b;
  logic              lst;
  logic              at_lim, is_eq, is_digit, is_sep;
  logic [XW-1:0]     pos_x, pos1_x, pos_sat_x, cap_start, vend_x, vs_x;
  logic [XW-1:0]     len_x, len_cap;
  logic [TAG_W+3:0]  tag_ext;
  logic              tag_fits, ends, at_sep, valid;

  assign in_chan.ready = !skid_v_r;
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign b             = in_chan.data_byte;
  assign lst           = in_chan.last;

  assign at_lim    = (pos_r == LIM_P);
  assign pos_x     = XW'(pos_r);
  assign pos1_x    = pos_x + XW'(1);
  assign pos_sat_x = at_lim ? pos_x : pos1_x;
  assign cap_start = (pos1_x > CAP_X) ? CAP_X : pos1_x;

  assign is_eq    = (b == EQ_BYTE);
  assign is_digit = (b >= DIGIT_0) && (b <= DIGIT_9);
  assign is_sep   = (b == sep_r);

  // tag * 10 + digit as shift-add
  assign tag_ext  = ({4'b0, tag_r} << 3) + ({4'b0, tag_r} << 1)
                  + (TAG_W+4)'(b - DIGIT_0);
  assign tag_fits = (tag_ext[TAG_W+3:TAG_W] == 4'b0);

  always_comb begin
    in_value_nxt = in_value_r;
    tag_nxt      = tag_r;
    run_open_nxt = run_open_r;
    too_big_nxt  = too_big_r;
    vstart_nxt   = vstart_r;
    pos_nxt      = at_lim ? pos_r : pos_r + PW'(1);
    ovf_nxt      = ovf_r | at_lim;
    sum_nxt      = sum_r + b;
    fsum_nxt     = fsum_r;
    ends         = 1'b0;
    at_sep       = 1'b0;
    vend_x       = pos_sat_x;
    vs_x         = XW'(vstart_r);

    if (!in_value_r) begin
      // Tag scan: '=' wins over the separator, digits only while the run is open
      if (is_eq) begin
        in_value_nxt = 1'b1;
        vstart_nxt   = cap_start[OFS_W-1:0];
        vs_x         = cap_start;
        ends         = lst;
      end else if (is_digit && run_open_r) begin
        if (!too_big_r) begin
          if (tag_fits) begin
            tag_nxt = tag_ext[TAG_W-1:0];
          end else begin
            too_big_nxt = 1'b1;
          end
        end
      end else begin
        run_open_nxt = 1'b0;
      end
    end else if (is_sep) begin
      ends   = 1'b1;
      at_sep = 1'b1;
      vend_x = pos_x;
    end else if (lst) begin
      ends = 1'b1;
    end

    valid   = ends && (tag_r != '0) && !too_big_r;
    len_x   = (vend_x >= vs_x) ? vend_x - vs_x : '0;
    len_cap = (len_x > CAP_X) ? CAP_X : len_x;
    has_res = valid || lst;

    res.field_valid      = valid;
    res.tag_number       = valid ? tag_r : '0;
    res.value_offset     = valid ? vs_x[OFS_W-1:0] : '0;
    res.value_length     = valid ? len_cap[OFS_W-1:0] : '0;
    res.sum_before_field = valid ? fsum_r : '0;
    res.message_end      = lst;
    res.length_overflow  = ovf_nxt;

    // Close the message on the last byte, else reopen a field after a separator
    if (lst) begin
      sum_nxt      = '0;
      pos_nxt      = '0;
      vstart_nxt   = '0;
      ovf_nxt      = 1'b0;
      in_value_nxt = 1'b0;
      tag_nxt      = '0;
      run_open_nxt = 1'b1;
      too_big_nxt  = 1'b0;
      fsum_nxt     = '0;
    end else if (at_sep) begin
      in_value_nxt = 1'b0;
      tag_nxt      = '0;
      run_open_nxt = 1'b1;
      too_big_nxt  = 1'b0;
      fsum_nxt     = sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r      <= SEP_RESET;
      in_value_r <= 1'b0;
      tag_r      <= '0;
      run_open_r <= 1'b1;
      too_big_r  <= 1'b0;
      pos_r      <= '0;
      vstart_r   <= '0;
      sum_r      <= '0;
      fsum_r     <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
      if (in_fire) begin
        in_value_r <= in_value_nxt;
        tag_r      <= tag_nxt;
        run_open_r <= run_open_nxt;
        too_big_r  <= too_big_nxt;
        pos_r      <= pos_nxt;
        vstart_r   <= vstart_nxt;
        sum_r      <= sum_nxt;
        fsum_r     <= fsum_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  // Output side: the skid word is always older than a new result
  assign push     = in_fire && has_res;
  assign out_free = !out_v_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= push;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.field_valid      = out_r.field_valid;
  assign out_chan.tag_number       = out_r.tag_number;
  assign out_chan.value_offset     = out_r.value_offset;
  assign out_chan.value_length     = out_r.value_length;
  assign out_chan.sum_before_field = out_r.sum_before_field;
  assign out_chan.message_end      = out_r.message_end;
  assign out_chan.length_overflow  = out_r.length_overflow;

  // Skid word only exists behind a held result word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full with result register empty");

  // Last byte clears the message state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && lst |=> (pos_r == '0) && !in_value_r && !ovf_r && (sum_r == '0))
    else $error("message state not cleared after last byte");

  // A reported field never carries tag zero
  a_field_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.field_valid |-> (out_r.tag_number != '0))
    else $error("field reported with tag zero");

  // Byte position saturates at the size bound
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LIM_P)
    else $error("byte position beyond size bound");

  // Every accepted last byte yields a result word
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && lst |=> out_v_r)
    else $error("no result after last byte");

endmodule

`default_nettype wire

// ===== dv/fix_tag_value_tokenizer_checker.sv =====
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer_checker
// Watches both channels of the FIX tokeniser, predicts every result word from
// the accepted bytes and compares the words that come out, field by field.
// ----------------------------------------------------------------------------
module fix_tag_value_tokenizer_checker #(
  parameter int unsigned MAX_MSG_BYTES = ftv_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ftv_pkg::BYTE_W-1:0] cfg_wdata,
  ftv_in_if                          in_mon,
  ftv_out_if                         out_mon,
  output int                         failures,
  output int                         outstanding,
  output int                         results_checked,
  output int                         fields_reported,
  output int                         overflow_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import ftv_pkg::*;

  localparam int unsigned POS_LIMIT  = MAX_MSG_BYTES;
  localparam int unsigned OFFSET_CAP =
    (MAX_MSG_BYTES - 1 < OFS_MAX) ? MAX_MSG_BYTES - 1 : OFS_MAX;
  localparam longint unsigned TAG_LIMIT = 64'h7FFF_FFFF;

  // Scan state of the message being parsed
  logic [BYTE_W-1:0] sep_byte;
  logic              scanning_value;
  logic [31:0]       tag_acc;
  logic              digits_open;
  logic              tag_overrange;
  int unsigned       byte_pos;
  logic [OFS_W-1:0]  value_start;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] field_sum;
  logic              overflow_seen;

  ftv_result_t field_reports_q[$];

  function automatic logic [OFS_W-1:0] cap_offset(input int unsigned v);
    return (v > OFFSET_CAP) ? OFS_W'(OFFSET_CAP) : OFS_W'(v);
  endfunction

  task automatic start_field();
    scanning_value = 1'b0;
    tag_acc        = '0;
    digits_open    = 1'b1;
    tag_overrange  = 1'b0;
    field_sum      = running_sum;
  endtask

  task automatic clear_message();
    running_sum   = '0;
    byte_pos      = 0;
    value_start   = '0;
    overflow_seen = 1'b0;
    start_field();
  endtask

  // Advance the scan by one byte and queue the word it yields, if any
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int unsigned     pos;
    int unsigned     value_end;
    int unsigned     span;
    longint unsigned widened;
    logic            ends;
    logic            at_sep;
    logic            reportable;
    ftv_result_t     res;
    pos       = byte_pos;
    value_end = 0;
    ends      = 1'b0;
    at_sep    = 1'b0;
    if (pos >= POS_LIMIT) begin
      overflow_seen = 1'b1;
      pos = POS_LIMIT;
    end
    byte_pos = (pos + 1 > POS_LIMIT) ? POS_LIMIT : pos + 1;

    if (!scanning_value) begin
      if (b == EQ_BYTE) begin
        scanning_value = 1'b1;
        value_start    = cap_offset(pos + 1);
        if (lst) begin
          ends      = 1'b1;
          value_end = byte_pos;
        end
      end else if (b >= DIGIT_0 && b <= DIGIT_9 && digits_open) begin
        if (!tag_overrange) begin
          widened = 64'(tag_acc) * 64'd10 + 64'(b - DIGIT_0);
          if (widened > TAG_LIMIT) tag_overrange = 1'b1;
          else tag_acc = widened[31:0];
        end
      end else begin
        digits_open = 1'b0;
      end
    end else if (b == sep_byte) begin
      ends      = 1'b1;
      at_sep    = 1'b1;
      value_end = pos;
    end else if (lst) begin
      ends      = 1'b1;
      value_end = byte_pos;
    end

    running_sum = running_sum + b;
    reportable  = ends && (tag_acc != 0) && !tag_overrange;

    if (reportable || lst) begin
      res = '0;
      if (reportable) begin
        span = (value_end >= 32'(value_start)) ? value_end - 32'(value_start) : 0;
        res.field_valid      = 1'b1;
        res.tag_number       = tag_acc[TAG_W-1:0];
        res.value_offset     = value_start;
        res.value_length     = cap_offset(span);
        res.sum_before_field = field_sum;
      end
      res.message_end     = lst;
      res.length_overflow = overflow_seen;
      field_reports_q = {field_reports_q, res};
    end

    if (lst) clear_message();
    else if (at_sep) start_field();
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    failures++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
  endtask

  task automatic compare_word(input ftv_result_t want, input ftv_result_t got);
    if (got.field_valid !== want.field_valid)
      flag_field("field_valid", 32'(want.field_valid), 32'(got.field_valid));
    if (got.tag_number !== want.tag_number)
      flag_field("tag_number", 32'(want.tag_number), 32'(got.tag_number));
    if (got.value_offset !== want.value_offset)
      flag_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
    if (got.value_length !== want.value_length)
      flag_field("value_length", 32'(want.value_length), 32'(got.value_length));
    if (got.sum_before_field !== want.sum_before_field)
      flag_field("sum_before_field", 32'(want.sum_before_field),
                 32'(got.sum_before_field));
    if (got.message_end !== want.message_end)
      flag_field("message_end", 32'(want.message_end), 32'(got.message_end));
    if (got.length_overflow !== want.length_overflow)
      flag_field("length_overflow", 32'(want.length_overflow),
                 32'(got.length_overflow));
  endtask

  always @(posedge clk) begin : monitor
    ftv_result_t got;
    if (!rst_n) begin
      sep_byte = SEP_RESET;
      clear_message();
      field_reports_q.delete();
    end else begin
      if (cfg_we) sep_byte = cfg_wdata;

      if (out_mon.valid && out_mon.ready) begin
        got.field_valid      = out_mon.field_valid;
        got.tag_number       = out_mon.tag_number;
        got.value_offset     = out_mon.value_offset;
        got.value_length     = out_mon.value_length;
        got.sum_before_field = out_mon.sum_before_field;
        got.message_end      = out_mon.message_end;
        got.length_overflow  = out_mon.length_overflow;
        results_checked++;
        if (got.field_valid === 1'b1) fields_reported++;
        if (got.length_overflow === 1'b1) overflow_results++;
        if (field_reports_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result word, expected none, got 0x%0h", $time, got);
        end else begin
          compare_word(field_reports_q.pop_front(), got);
        end
      end

      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.data_byte, in_mon.last);
    end
    outstanding <= field_reports_q.size();
  end

endmodule

// ===== dv/fix_tag_value_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer_tb
// Feeds FIX messages byte by byte through the tokeniser under several
// separators, with random gaps on both channels, and leaves the checking of
// every result word to the checker beside the block.
// ----------------------------------------------------------------------------
module fix_tag_value_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftv_pkg::*;

  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 10;
  localparam int LONG_HOLD        = 80;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int BYTES_PER_SETTING = 205;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  ftv_in_if  in_chan ();
  ftv_out_if out_chan ();

  int failures;
  int outstanding;
  int results_checked;
  int fields_reported;
  int overflow_results;

  // Long receiver hold-offs are asked for by bumping this count
  int hold_reqs   = 0;
  int idle_cycles = 0;

  // Message under construction and run tallies
  logic [BYTE_W-1:0] cur_sep;
  logic [BYTE_W-1:0] msg_q[$];
  logic [BYTE_W-1:0] sep_plan[5];
  bit                eager_msg;
  int                bytes_sent;
  int                messages_sent;
  int                settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fix_tag_value_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  fix_tag_value_tokenizer_checker field_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mon           (in_chan),
    .out_mon          (out_chan),
    .failures         (failures),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .fields_reported  (fields_reported),
    .overflow_results (overflow_results)
  );

  // Gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Value text: any byte but the separator, with '=' turning up often
  function automatic logic [BYTE_W-1:0] value_byte();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 9) == 0 && cur_sep != EQ_BYTE) return EQ_BYTE;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == cur_sep);
    return b;
  endfunction

  // Tag text: mostly plain tags, plus the limits of 31 bits, leading zeros,
  // no leading digit, digits broken by other text, and nothing at all
  function automatic string tag_text();
    int              roll;
    longint unsigned v;
    roll = $urandom_range(0, 99);
    if (roll < 65) v = 64'($urandom_range(1, 999));
    else if (roll < 75) v = 64'($urandom_range(1000, 2000000000));
    else if (roll < 80) v = roll[0] ? 64'd2147483647 : 64'd2147483646;
    else if (roll < 85) begin
      case ($urandom_range(0, 2))
        0:       v = 64'd2147483648;
        1:       v = 64'd4294967295;
        default: v = 64'd99999999999;
      endcase
    end
    else if (roll < 90) return $sformatf("00%0d", $urandom_range(0, 9));
    else if (roll < 95) return $sformatf("X%0d", $urandom_range(1, 99));
    else if (roll < 98) return $sformatf("%0dA%0d", $urandom_range(1, 99), $urandom_range(0, 9));
    else return "";
    return $sformatf("%0d", v);
  endfunction

  // Append one byte to the message under construction
  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    msg_q = {msg_q, b};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // Fields of tag '=' value, split by the current separator; now and then
  // the '=' goes missing, and the message may or may not end on a separator
  task automatic build_fields(input int n_fields, input int max_value);
    for (int f = 0; f < n_fields; f++) begin
      push_text(tag_text());
      if ($urandom_range(0, 19) != 0) queue_byte(EQ_BYTE);
      repeat ($urandom_range(0, max_value)) queue_byte(value_byte());
      if (f < n_fields - 1 || $urandom_range(0, 1) == 1) queue_byte(cur_sep);
    end
    if (msg_q.size() == 0) queue_byte(value_byte());
  endtask

  task automatic build_random_message();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      build_fields($urandom_range(1, 6), 8);
    end else if (roll < 85) begin
      // cut short part-way through a field
      build_fields($urandom_range(1, 4), 8);
      repeat ($urandom_range(1, 3)) if (msg_q.size() > 1) void'(msg_q.pop_back());
    end else begin
      // noise, biased towards the bytes that steer the scan
      repeat ($urandom_range(1, 24)) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) queue_byte(EQ_BYTE);
        else if (roll < 25) queue_byte(cur_sep);
        else if (roll < 45) queue_byte(BYTE_W'(DIGIT_0 + $urandom_range(0, 9)));
        else queue_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Offer one word and hold it until the block takes it. valid stays high
  // into the next word when there is no gap, so it never drops and rises
  // within one step.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int gap;
    gap = eager_msg ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last      <= lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the built message with last on its final byte, then drop it
  task automatic send_message(input bit no_gaps);
    eager_msg = no_gaps || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    messages_sent++;
    msg_q.delete();
  endtask

  // Hold off the input until every expected word is out, then let the block
  // settle in case the last bytes gave no word at all
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic [BYTE_W-1:0] sep);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= sep;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_sep = sep;
    settings_used++;
  endtask

  // Result side: random gaps after each taken word, stretches of steady
  // ready, and a long hold-off whenever the stimulus asks for one
  initial begin : result_sink
    int hold_left;
    int gap_left;
    int served;
    int mode_left;
    bit steady;
    hold_left = 0;
    gap_left  = 0;
    served    = 0;
    mode_left = 0;
    steady    = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_reqs != served) begin
        served    = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (out_chan.valid && out_chan.ready && !steady) gap_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still due",
               $time, idle_cycles, outstanding);
      $display("fix_tag_value_tokenizer_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase_end;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.last      <= 1'b0;
    cur_sep       = SEP_RESET;
    bytes_sent    = 0;
    messages_sent = 0;
    settings_used = 1;
    eager_msg     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, on the reset separator.
    // All-ones byte and '=' inside a value, then a separator inside tag text
    // that stops the digits, so the second field reports tag 4.
    push_text("1=");
    queue_byte(8'hFF);
    queue_byte(EQ_BYTE);
    queue_byte(SEP_RESET);
    push_text("4");
    queue_byte(SEP_RESET);
    push_text("5=z");
    send_message(1'b0);
    // no leading digit: tag 0, dropped, closing word carries field_valid 0
    queue_byte(EQ_BYTE);
    queue_byte(8'h00);
    send_message(1'b0);
    // '=' as the final byte: reported with an empty value
    push_text("9=");
    send_message(1'b0);
    // no '=' at all: ignored
    push_text("a");
    send_message(1'b0);
    // one past the largest 31-bit tag: dropped
    push_text("2147483648=");
    send_message(1'b0);

    // Sender pauses here until every expected word has come out
    drain();

    // Random phases: zero, all-ones and '=' as separator, one random pick,
    // and back to SOH
    sep_plan    = '{8'h00, 8'hFF, EQ_BYTE, 8'h00, SEP_RESET};
    sep_plan[3] = BYTE_W'($urandom_range(0, 255));
    foreach (sep_plan[s]) begin
      write_separator(sep_plan[s]);
      phase_end = bytes_sent + BYTES_PER_SETTING;
      if (s == 0) begin
        // Hold the receiver off while short fields pour in, so the result
        // register and skid stage fill and the input stalls
        hold_reqs <= hold_reqs + 1;
        repeat (16) begin
          push_text($sformatf("%0d=", $urandom_range(1, 99)));
          queue_byte(value_byte());
          queue_byte(cur_sep);
        end
        send_message(1'b1);
      end
      while (bytes_sent < phase_end) begin
        build_random_message();
        send_message(1'b0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages over %0d separator settings.",
             bytes_sent, messages_sent, settings_used);
    $display("Checked %0d result words: %0d field reports, %0d with length overflow.",
             results_checked, fields_reported, overflow_results);
    if (failures == 0 && outstanding == 0) begin
      $display("fix_tag_value_tokenizer_tb OK");
    end else begin
      $display("fix_tag_value_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
